// ===== rtl/core/pixel_fog_point_light_shader_core_macros.svh =====
// assertion macros shared by the shader core
`ifndef PIXEL_FOG_POINT_LIGHT_SHADER_CORE_MACROS_SVH
`define PIXEL_FOG_POINT_LIGHT_SHADER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define PFPLS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pfpls: property failed");

// next-cycle implication
`define PFPLS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pfpls: property failed");

`endif

// ===== rtl/core/pfpls_pkg.sv =====
// types, constants and helpers of the shader core
package pfpls_pkg;

  localparam int unsigned MaxLights = 8;
  localparam int unsigned LightIdxW = $clog2(MaxLights);
  localparam int unsigned CountW    = 4;
  localparam int unsigned SqrtSteps = 24;
  localparam int unsigned DivSteps  = 16;
  localparam int unsigned IterW     = 5;

  localparam logic OpcShade = 1'b0;
  localparam logic OpcLoad  = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_FOG_T, ST_FOG, ST_AMB1, ST_AMB2, ST_LCHK, ST_SQ, ST_CMP,
    ST_SQRT, ST_DIV_INIT, ST_DIV, ST_T2, ST_ST, ST_ACC, ST_FIN1, ST_FIN2
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CAPTURE, OP_FOG_T, OP_FOG, OP_AMB1, OP_AMB2,
    OP_LCHK, OP_SQ, OP_CMP, OP_SQRT, OP_DIV_INIT, OP_DIV, OP_T2, OP_ST,
    OP_ACC, OP_FIN1, OP_FIN2
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   skip;   // drop current light, move to the next
  } dp_cmd_t;

  typedef struct packed {
    logic lights_done;
    logic light_off;
    logic light_miss;
  } dp_status_t;

  function automatic logic [8:0] sat256(input logic [8:0] v);
    sat256 = (v > 9'd256) ? 9'd256 : v;
  endfunction

endpackage

// ===== rtl/core/pfpls_ctrl.sv =====
// sequencer of the shader core
module pfpls_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_opcode_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  pfpls_pkg::dp_status_t status_i,
  output pfpls_pkg::dp_cmd_t   cmd_o
);
  import pfpls_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [IterW-1:0] iter_q, iter_d;
  logic             out_valid_q, out_valid_d;
  logic             fin_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    iter_d     = iter_q;
    cmd_o.op   = OP_NONE;
    cmd_o.skip = 1'b0;
    in_ready_o = 1'b0;
    fin_fire   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_opcode_i == OpcLoad) begin
            cmd_o.op = OP_LOAD;
          end else begin
            cmd_o.op = OP_CAPTURE;
            state_d  = ST_FOG_T;
          end
        end
      end
      ST_FOG_T: begin
        cmd_o.op = OP_FOG_T;
        state_d  = ST_FOG;
      end
      ST_FOG: begin
        cmd_o.op = OP_FOG;
        state_d  = ST_AMB1;
      end
      ST_AMB1: begin
        cmd_o.op = OP_AMB1;
        state_d  = ST_AMB2;
      end
      ST_AMB2: begin
        cmd_o.op = OP_AMB2;
        state_d  = ST_LCHK;
      end
      ST_LCHK: begin
        if (status_i.lights_done) begin
          state_d = ST_FIN1;
        end else if (status_i.light_off) begin
          cmd_o.skip = 1'b1;
        end else begin
          cmd_o.op = OP_LCHK;
          state_d  = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.op = OP_SQ;
        state_d  = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.op = OP_CMP;
        iter_d   = '0;
        if (status_i.light_miss) begin
          cmd_o.skip = 1'b1;
          state_d    = ST_LCHK;
        end else begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd_o.op = OP_SQRT;
        iter_d   = iter_q + 1'b1;
        if (iter_q == IterW'(SqrtSteps - 1)) begin
          state_d = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd_o.op = OP_DIV_INIT;
        iter_d   = '0;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        iter_d   = iter_q + 1'b1;
        if (iter_q == IterW'(DivSteps - 1)) begin
          state_d = ST_T2;
        end
      end
      ST_T2: begin
        cmd_o.op = OP_T2;
        state_d  = ST_ST;
      end
      ST_ST: begin
        cmd_o.op = OP_ST;
        state_d  = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.op = OP_ACC;
        state_d  = ST_LCHK;
      end
      ST_FIN1: begin
        cmd_o.op = OP_FIN1;
        state_d  = ST_FIN2;
      end
      ST_FIN2: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_FIN2;
          fin_fire = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || fin_fire;
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/pfpls_dp.sv =====
// datapath of the shader core: light table, fog, sqrt, divide, banding
module pfpls_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pfpls_pkg::dp_cmd_t    cmd_i,
  output pfpls_pkg::dp_status_t status_o,
  input  logic                  cfg_valid_i,
  input  logic [3:0]            cfg_active_lights_i,
  input  logic [2:0]            light_slot_i,
  input  logic [31:0]           pixel_rgba_i,
  input  logic [15:0]           view_dist_i,
  input  logic [8:0]            sector_level_i,
  input  logic [8:0]            color_r_i,
  input  logic [8:0]            color_g_i,
  input  logic [8:0]            color_b_i,
  input  logic [23:0]           pos_x_i,
  input  logic [23:0]           pos_y_i,
  input  logic [15:0]           light_radius_i,
  input  logic [11:0]           light_strength_i,
  output logic [31:0]           lit_rgba_o
);
  import pfpls_pkg::*;

  // light table
  logic [23:0] lpx_q  [MaxLights];
  logic [23:0] lpy_q  [MaxLights];
  logic [15:0] lrad_q [MaxLights];
  logic [11:0] lstr_q [MaxLights];
  logic [26:0] ltint_q[MaxLights];

  logic [CountW-1:0] active_q, idx_q, n_lights;
  logic [LightIdxW-1:0] e;

  // pixel request
  logic [31:0] pix_q;
  logic [15:0] d_q;
  logic [8:0]  lvl_q;
  logic [8:0]  col_q [3];
  logic [23:0] px_q, py_q;

  logic [15:0] ft_q;
  logic [16:0] fog_q;
  logic [13:0] lift_q;
  logic [16:0] lc_q  [3];
  logic [32:0] amb_q [3];
  logic [23:0] ch_q  [3];

  // per-light
  logic [23:0] adx_q, ady_q;
  logic [15:0] rad_q;
  logic [11:0] str_q;
  logic [31:0] r2_q;
  logic [8:0]  lt_q [3];
  logic [47:0] sqx_q, sqy_q;
  logic [47:0] sv_q;
  logic [23:0] root_q;
  logic [26:0] srem_q;
  logic [23:0] drem_q;
  logic [15:0] dq_q;
  logic        full_q;
  logic [16:0] t2_q;
  logic [28:0] st_q;

  // banding
  logic [16:0] chf_q [3];
  logic [3:0]  bq_q  [3];
  logic [31:0] lit_q;

  // combinational
  logic signed [24:0] dx, dy;
  logic [48:0] d2;
  logic [12:0] fdiff;
  logic [19:0] fz;
  logic [44:0] fprod;
  logic [32:0] fsq;
  logic [30:0] lprod;
  logic [26:0] rem_n, trial;
  logic [23:0] rr;
  logic [24:0] rem2;
  logic [16:0] tfull;
  logic [33:0] tsq;
  logic [47:0] amb_p [3];
  logic [37:0] acc_p [3];
  logic [16:0] c1 [3], c2 [3];
  logic [20:0] q15 [3];
  logic [7:0]  byte_v [3];
  logic [25:0] lo_p [3];
  logic [11:0] bq_p [3];
  logic [12:0] yq [3];
  logic [26:0] hi_p [3];
  logic [8:0]  v [3];
  logic [7:0]  vs [3];

  assign n_lights = (active_q > CountW'(MaxLights)) ? CountW'(MaxLights) : active_q;
  assign e        = idx_q[LightIdxW-1:0];

  assign status_o.lights_done = (idx_q >= n_lights);
  assign status_o.light_off   = (lrad_q[e] == '0) || (lstr_q[e] == '0);
  assign d2                   = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign status_o.light_miss  = (d2 >= {17'd0, r2_q});

  always_comb begin
    dx    = $signed({px_q[23], px_q}) - $signed({lpx_q[e][23], lpx_q[e]});
    dy    = $signed({py_q[23], py_q}) - $signed({lpy_q[e][23], lpy_q[e]});
    // fog ramp: t = round((7168-d)*65536/5632), /11 by reciprocal
    fdiff = 13'(16'd7168 - d_q);
    fz    = {fdiff, 7'd0} + 20'd5;
    fprod = {25'd0, fz} * 45'd24403224;
    fsq   = {17'd0, ft_q} * {17'd0, ft_q} + 33'd32768;
    lprod = {14'd0, fog_q} * 31'd12124 + 31'd32768;
    // sqrt step
    rem_n = {srem_q[24:0], sv_q[47:46]};
    trial = {1'b0, root_q, 2'b01};
    // divide step
    rr    = {rad_q, 8'd0};
    rem2  = {drem_q, 1'b0};
    tfull = full_q ? 17'h10000 : {1'b0, dq_q};
    tsq   = {17'd0, tfull} * {17'd0, tfull} + 34'd32768;
    for (int c = 0; c < 3; c++) begin
      amb_p[c]  = {15'd0, amb_q[c]} * 48'd29491;
      acc_p[c]  = {9'd0, st_q} * {29'd0, lt_q[c]} + 38'd32768;
      c1[c]     = (ch_q[c] > 24'h10000) ? 17'h10000 : ch_q[c][16:0];
      c2[c]     = (c1[c] < {3'd0, lift_q}) ? {3'd0, lift_q} : c1[c];
      q15[c]    = ({c2[c], 4'd0} - {4'd0, c2[c]}) + 21'd32768;
      byte_v[c] = pix_q[16 - 8*c +: 8];
      lo_p[c]   = {18'd0, byte_v[c]} * {9'd0, chf_q[c]} + 26'd32768;
      bq_p[c]   = {4'd0, byte_v[c]} * {8'd0, bq_q[c]};
      yq[c]     = {bq_p[c], 1'b0} + 13'd15;
      hi_p[c]   = {14'd0, yq[c]} * 27'd8739;
      v[c]      = (chf_q[c] < 17'd5243) ? lo_p[c][24:16] : hi_p[c][26:18];
      vs[c]     = (v[c] > 9'd255) ? 8'hFF : v[c][7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      idx_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        active_q <= cfg_active_lights_i;
      end
      if (cmd_i.op == OP_AMB2) begin
        idx_q <= '0;
      end else if (cmd_i.skip || cmd_i.op == OP_ACC) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        lpx_q[light_slot_i]   <= pos_x_i;
        lpy_q[light_slot_i]   <= pos_y_i;
        lrad_q[light_slot_i]  <= light_radius_i;
        lstr_q[light_slot_i]  <= light_strength_i;
        ltint_q[light_slot_i] <= {color_b_i, color_g_i, color_r_i};
      end
      OP_CAPTURE: begin
        pix_q    <= pixel_rgba_i;
        d_q      <= view_dist_i;
        lvl_q    <= sat256(sector_level_i);
        col_q[0] <= sat256(color_r_i);
        col_q[1] <= sat256(color_g_i);
        col_q[2] <= sat256(color_b_i);
        px_q     <= pos_x_i;
        py_q     <= pos_y_i;
      end
      OP_FOG_T: begin
        ft_q <= fprod[43:28];
        for (int c = 0; c < 3; c++) begin
          lc_q[c] <= 17'({9'd0, lvl_q} * {9'd0, col_q[c]});
        end
      end
      OP_FOG: begin
        if (d_q <= 16'd1536) begin
          fog_q <= 17'h10000;
        end else if (d_q >= 16'd7168) begin
          fog_q <= '0;
        end else begin
          fog_q <= fsq[32:16];
        end
      end
      OP_AMB1: begin
        lift_q <= lprod[29:16];
        for (int c = 0; c < 3; c++) begin
          amb_q[c] <= 33'({17'd0, lc_q[c]} * {17'd0, fog_q});
        end
      end
      OP_AMB2: begin
        for (int c = 0; c < 3; c++) begin
          ch_q[c] <= {9'd0, amb_p[c][46:32] + 15'(amb_p[c][31])};
        end
      end
      OP_LCHK: begin
        adx_q <= dx[24] ? 24'(-dx) : dx[23:0];
        ady_q <= dy[24] ? 24'(-dy) : dy[23:0];
        rad_q <= lrad_q[e];
        str_q <= lstr_q[e];
        r2_q  <= {16'd0, lrad_q[e]} * {16'd0, lrad_q[e]};
        for (int c = 0; c < 3; c++) begin
          lt_q[c] <= sat256(ltint_q[e][9*c +: 9]);
        end
      end
      OP_SQ: begin
        sqx_q <= {24'd0, adx_q} * {24'd0, adx_q};
        sqy_q <= {24'd0, ady_q} * {24'd0, ady_q};
      end
      OP_CMP: begin
        sv_q   <= {d2[31:0], 16'd0};
        root_q <= '0;
        srem_q <= '0;
      end
      OP_SQRT: begin
        sv_q <= {sv_q[45:0], 2'b00};
        if (rem_n >= trial) begin
          srem_q <= rem_n - trial;
          root_q <= {root_q[22:0], 1'b1};
        end else begin
          srem_q <= rem_n;
          root_q <= {root_q[22:0], 1'b0};
        end
      end
      OP_DIV_INIT: begin
        drem_q <= rr - root_q;
        full_q <= (root_q == '0);
        dq_q   <= '0;
      end
      OP_DIV: begin
        if (rem2 >= {1'b0, rr}) begin
          drem_q <= 24'(rem2 - {1'b0, rr});
          dq_q   <= {dq_q[14:0], 1'b1};
        end else begin
          drem_q <= rem2[23:0];
          dq_q   <= {dq_q[14:0], 1'b0};
        end
      end
      OP_T2: begin
        t2_q <= tsq[32:16];
      end
      OP_ST: begin
        st_q <= {17'd0, str_q} * {12'd0, t2_q};
      end
      OP_ACC: begin
        for (int c = 0; c < 3; c++) begin
          ch_q[c] <= ch_q[c] + {2'd0, acc_p[c][37:16]};
        end
      end
      OP_FIN1: begin
        for (int c = 0; c < 3; c++) begin
          chf_q[c] <= c2[c];
          bq_q[c]  <= q15[c][19:16];
        end
      end
      OP_FIN2: begin
        lit_q <= {pix_q[31:24], vs[0], vs[1], vs[2]};
      end
      default: begin
      end
    endcase
  end

  assign lit_rgba_o = lit_q;

endmodule

// ===== rtl/core/pixel_fog_point_light_shader_core.sv =====
// top level of the fog and point light pixel shader core
//
//  channel | handshake                | payload
//  --------+--------------------------+-----------------------------------------
//  in      | in_valid_i / in_ready_o  | opcode, slot, pixel, dist, level, color,
//          |                          | position, radius, strength
//  out     | out_valid_o / out_ready_i| lit_rgba_o
//  cfg     | cfg_valid_i / cfg_ready_o| cfg_active_lights_i
//
// a load request writes one light table slot and returns no result
// a shade request runs fog and ambient, then per active light a skip if disabled,
//   else a range check and, if in range, a 24-step sqrt and 16-step divide
// one request is worked at a time; the result register lets the next
//   request in while a finished result still waits
// reset is asynchronous active low; the light table is not cleared
`include "pixel_fog_point_light_shader_core_macros.svh"
module pixel_fog_point_light_shader_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        opcode_i,
  input  logic [2:0]  light_slot_i,
  input  logic [31:0] pixel_rgba_i,
  input  logic [15:0] view_dist_i,
  input  logic [8:0]  sector_level_i,
  input  logic [8:0]  color_r_i,
  input  logic [8:0]  color_g_i,
  input  logic [8:0]  color_b_i,
  input  logic [23:0] pos_x_i,
  input  logic [23:0] pos_y_i,
  input  logic [15:0] light_radius_i,
  input  logic [11:0] light_strength_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] lit_rgba_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_active_lights_i
);
  import pfpls_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // register writes land at once
  assign cfg_ready_o = 1'b1;

  // sequencer: walks fog, ambient, each light, then banding
  pfpls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (opcode_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and the light table
  pfpls_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_active_lights_i (cfg_active_lights_i),
    .light_slot_i        (light_slot_i),
    .pixel_rgba_i        (pixel_rgba_i),
    .view_dist_i         (view_dist_i),
    .sector_level_i      (sector_level_i),
    .color_r_i           (color_r_i),
    .color_g_i           (color_g_i),
    .color_b_i           (color_b_i),
    .pos_x_i             (pos_x_i),
    .pos_y_i             (pos_y_i),
    .light_radius_i      (light_radius_i),
    .light_strength_i    (light_strength_i),
    .lit_rgba_o          (lit_rgba_o)
  );

  // a shade request keeps the input closed the next cycle
  `PFPLS_ASSERT_NXT(a_shade_busy, in_valid_i && in_ready_o && (opcode_i == OpcShade), !in_ready_o)
  // a load request leaves the input open the next cycle
  `PFPLS_ASSERT_NXT(a_load_quick, in_valid_i && in_ready_o && (opcode_i == OpcLoad), in_ready_o)
  // a new result only appears at the end of a busy stretch
  `PFPLS_ASSERT_IMP(a_res_from_work, $rose(out_valid_o), !$past(in_ready_o))

endmodule
